// ===== sv/fcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types, kernel coefficients and constants for the five-point cubic
// smoother.
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int TAPS          = 5;
    localparam int SAMPLE_W      = 16;
    localparam int COEF_W        = 8;
    localparam int PROD_W        = 24;
    localparam int MAG_W         = 23;
    localparam int IDX_W         = 3;
    localparam int CNT_W         = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int DIV_BASE      = 35;
    localparam int RECIP_SHIFT   = 28;
    localparam int RECIP_W       = 23;
    localparam int RECIP_PROD_W  = MAG_W + RECIP_W;
    localparam int QUOT_W        = RECIP_PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_35 = RECIP_W'((2 ** RECIP_SHIFT) / DIV_BASE);

    localparam logic [IDX_W-1:0] K_FIRST  = IDX_W'(0);
    localparam logic [IDX_W-1:0] K_SECOND = IDX_W'(1);
    localparam logic [IDX_W-1:0] K_MID    = IDX_W'(2);
    localparam logic [IDX_W-1:0] K_LAST   = IDX_W'(4);

    localparam logic signed [COEF_W-1:0] KERN [TAPS][TAPS] = '{
        '{ 8'sd69,  8'sd4,  -8'sd6,  8'sd4,  -8'sd1},
        '{ 8'sd2,   8'sd27,  8'sd12, -8'sd8,  8'sd2},
        '{-8'sd3,   8'sd12,  8'sd17,  8'sd12, -8'sd3},
        '{ 8'sd2,  -8'sd8,   8'sd12,  8'sd27,  8'sd2},
        '{-8'sd1,   8'sd4,  -8'sd6,   8'sd4,  8'sd69}
    };

    typedef enum logic [1:0] {
        DIV_ONE,
        DIV_35,
        DIV_70
    } div_sel_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_last;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smoothed;
        logic                       run_last;
        logic                       block_end;
    } result_t;

    typedef struct packed {
        logic [TAPS-1:0][SAMPLE_W-1:0] win;
        logic [IDX_W-1:0]              start;
        logic [IDX_W-1:0]              stop;
        logic                          pass;
        logic                          last;
    } job_t;

    function automatic logic signed [COEF_W-1:0] coef(
        input logic             pass,
        input logic [IDX_W-1:0] k,
        input logic [IDX_W-1:0] i
    );
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (pass)
        begin
            c = (k == i) ? COEF_W'(1) : '0;
        end
        else
        begin
            case (k)
                3'd0:    c = KERN[0][i];
                3'd1:    c = KERN[1][i];
                3'd2:    c = KERN[2][i];
                3'd3:    c = KERN[3][i];
                3'd4:    c = KERN[4][i];
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

// ===== sv/fcs_front.sv =====
// ----------------------------------------------------------------------------
// fcs_front
// Sample window and block counter; turns each accepted sample that causes
// results into a job that lists those results.
// ----------------------------------------------------------------------------
module fcs_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    output logic             stall,
    input  fcs_pkg::sample_t data,
    input  logic             queue_full,
    output logic             push,
    output fcs_pkg::job_t    job
);
    import fcs_pkg::*;

    logic [TAPS-1:0][SAMPLE_W-1:0] win_reg;
    logic [TAPS-1:0][SAMPLE_W-1:0] win_next;
    logic [CNT_W-1:0]              seen_reg;
    logic [CNT_W-1:0]              seen_next;
    logic [CNT_W-1:0]              cnt;
    logic                          accept;
    logic                          fresh;

    assign stall  = queue_full;
    assign accept = valid && !queue_full;
    assign fresh  = (seen_reg == CNT_W'(TAPS - 1));
    assign cnt    = (seen_reg < CNT_W'(TAPS)) ? seen_reg + CNT_W'(1) : CNT_W'(TAPS);
    assign win_next = {data.sample, win_reg[TAPS-1:1]};

    always_comb
    begin
        seen_next = seen_reg;
        if (accept)
        begin
            seen_next = data.block_last ? '0 : cnt;
        end
    end

    always_comb
    begin
        job.win   = win_next;
        job.last  = data.block_last;
        job.pass  = 1'b0;
        job.start = K_MID;
        job.stop  = K_MID;
        push      = 1'b0;
        if (cnt == CNT_W'(TAPS))
        begin
            job.start = fresh ? K_FIRST : K_MID;
            job.stop  = data.block_last ? K_LAST : K_MID;
            push      = accept;
        end
        else if (data.block_last)
        begin
            job.pass  = 1'b1;
            job.start = IDX_W'(TAPS) - cnt;
            job.stop  = K_LAST;
            push      = accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            win_reg  <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            if (accept)
            begin
                win_reg <= win_next;
            end
        end
    end

endmodule

// ===== sv/fcs_queue.sv =====
// ----------------------------------------------------------------------------
// fcs_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module fcs_queue #(
    parameter int DEPTH = fcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fcs_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output fcs_pkg::job_t head_job
);
    import fcs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (occ_reg == OCC_W'(DEPTH));
    assign head_valid = (occ_reg != '0);
    assign head_job   = slot_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        occ_next = occ_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            occ_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/fcs_back.sv =====
// ----------------------------------------------------------------------------
// fcs_back
// Steps through each job's results and runs them down the kernel pipeline:
// taps, sum, reciprocal multiply, correct and saturate.
// ----------------------------------------------------------------------------
module fcs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  fcs_pkg::job_t    head_job,
    output logic             pop,
    output logic             valid,
    input  logic             stall,
    output fcs_pkg::result_t data
);
    import fcs_pkg::*;

    localparam int SUM_W = PROD_W;

    // sequencer
    job_t             cur_reg;
    logic             cur_valid_reg;
    logic             cur_valid_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             adv;
    logic             issue;
    logic             at_stop;
    logic             done;

    // stage 1: tap products
    logic                            p1_valid_reg;
    logic signed [TAPS-1:0][PROD_W-1:0] p1_prod_reg;
    div_sel_t                        p1_div_reg;
    logic                            p1_run_reg;
    logic                            p1_end_reg;
    logic signed [TAPS-1:0][PROD_W-1:0] prod_next;
    div_sel_t                        div_next;

    // stage 2: magnitude
    logic             p2_valid_reg;
    logic [MAG_W-1:0] p2_mag_reg;
    logic             p2_neg_reg;
    div_sel_t         p2_div_reg;
    logic             p2_run_reg;
    logic             p2_end_reg;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0] abs_sum;
    logic [MAG_W-1:0] mag_next;

    // stage 3: reciprocal product
    logic                    p3_valid_reg;
    logic [RECIP_PROD_W-1:0] p3_prod_reg;
    logic [MAG_W-1:0]        p3_mag_reg;
    logic                    p3_neg_reg;
    div_sel_t                p3_div_reg;
    logic                    p3_run_reg;
    logic                    p3_end_reg;

    // output
    logic                       out_valid_reg;
    result_t                    out_reg;
    logic [QUOT_W-1:0]          q0;
    logic [QUOT_W-1:0]          q;
    logic [MAG_W:0]             q0x;
    logic [MAG_W:0]             rem;
    logic signed [SAMPLE_W-1:0] sat_val;

    assign adv     = !(out_valid_reg && stall);
    assign issue   = cur_valid_reg && adv;
    assign at_stop = (idx_reg == cur_reg.stop);
    assign done    = issue && at_stop;
    assign pop     = head_valid && (!cur_valid_reg || done);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = head_job.start;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        logic signed [PROD_W-1:0] ce;
        logic signed [PROD_W-1:0] we;
        for (int i = 0; i < TAPS; i++)
        begin
            ce = PROD_W'(coef(cur_reg.pass, idx_reg, IDX_W'(i)));
            we = PROD_W'($signed(cur_reg.win[i]));
            prod_next[i] = PROD_W'(ce * we);
        end
        if (cur_reg.pass)
        begin
            div_next = DIV_ONE;
        end
        else if (idx_reg == K_FIRST || idx_reg == K_LAST)
        begin
            div_next = DIV_70;
        end
        else
        begin
            div_next = DIV_35;
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            sum = sum + p1_prod_reg[i];
        end
        abs_sum  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        mag_next = (p1_div_reg == DIV_70) ? abs_sum[MAG_W:1] : abs_sum[MAG_W-1:0];
    end

    always_comb
    begin
        q0  = p3_prod_reg[RECIP_PROD_W-1:RECIP_SHIFT];
        q0x = (MAG_W + 1)'(q0) * (MAG_W + 1)'(DIV_BASE);
        rem = (MAG_W + 1)'(p3_mag_reg) - q0x;
        if (p3_div_reg == DIV_ONE)
        begin
            q = QUOT_W'(p3_mag_reg);
        end
        else if (rem >= (MAG_W + 1)'(DIV_BASE))
        begin
            q = q0 + QUOT_W'(1);
        end
        else
        begin
            q = q0;
        end
        if (p3_neg_reg)
        begin
            sat_val = (q >= QUOT_W'(32768)) ? 16'sh8000 : SAMPLE_W'(-q);
        end
        else
        begin
            sat_val = (q > QUOT_W'(32767)) ? 16'sh7fff : SAMPLE_W'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (adv)
            begin
                p1_valid_reg  <= issue;
                p2_valid_reg  <= p1_valid_reg;
                p3_valid_reg  <= p2_valid_reg;
                out_valid_reg <= p3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_job;
        end
        if (adv)
        begin
            p1_prod_reg <= prod_next;
            p1_div_reg  <= div_next;
            p1_run_reg  <= at_stop;
            p1_end_reg  <= at_stop && cur_reg.last;

            p2_mag_reg  <= mag_next;
            p2_neg_reg  <= sum[SUM_W-1];
            p2_div_reg  <= p1_div_reg;
            p2_run_reg  <= p1_run_reg;
            p2_end_reg  <= p1_end_reg;

            p3_prod_reg <= RECIP_PROD_W'(p2_mag_reg) * RECIP_PROD_W'(RECIP_35);
            p3_mag_reg  <= p2_mag_reg;
            p3_neg_reg  <= p2_neg_reg;
            p3_div_reg  <= p2_div_reg;
            p3_run_reg  <= p2_run_reg;
            p3_end_reg  <= p2_end_reg;

            out_reg.smoothed  <= sat_val;
            out_reg.run_last  <= p3_run_reg;
            out_reg.block_end <= p3_end_reg;
        end
    end

    assign valid = out_valid_reg;
    assign data  = out_reg;

endmodule

// ===== sv/five_point_cubic_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// five_point_cubic_smoother_unit
// Five-point cubic least-squares smoother over blocks of signed samples.
// ----------------------------------------------------------------------------
// One sample is taken per cycle while the job queue has room, and the back
// end delivers one result per cycle unless result_stall holds it. Most
// samples yield one result, the fifth sample of a block yields three and
// the flagged last sample three (five for a five-sample block, and the
// whole block, one to four results, for a shorter one), which the back end
// issues one after another. The job queue (QUEUE_DEPTH entries) absorbs
// such bursts; input stall rises only when it is full. Blocks shorter than
// five samples come out unchanged.
module five_point_cubic_smoother_unit #(
    parameter int QUEUE_DEPTH = fcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  fcs_pkg::sample_t sample_data,
    output logic             result_valid,
    input  logic             result_stall,
    output fcs_pkg::result_t result_data
);
    import fcs_pkg::*;

    job_t front_job;
    job_t head_job;
    logic push;
    logic full;
    logic pop;
    logic head_valid;

    fcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (sample_valid),
        .stall      (sample_stall),
        .data       (sample_data),
        .queue_full (full),
        .push       (push),
        .job        (front_job)
    );

    fcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (front_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    fcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .valid      (result_valid),
        .stall      (result_stall),
        .data       (result_data)
    );

endmodule
